[rtl/lbp_pkg.sv]
// lbp_pkg: shared types, register codes and pattern helper functions for the
// local binary pattern block. Depends on nothing; used by every rtl module.
package lbp_pkg;

    // fixed field widths of the block
    localparam int SAMPLE_FIELDS       = 8;
    localparam int PAT_W               = 8;
    localparam int LABEL_W             = 8;
    localparam int CNT_W               = 4;
    localparam int MODE_W              = 2;
    localparam int CFG_INDEX_W         = 1;
    localparam int CFG_DATA_W          = 4;
    localparam int POP_W               = 4;
    localparam int TAB_DEPTH           = 1 << PAT_W;

    // parameter defaults
    localparam int MAX_SAMPLES_DEFAULT = 8;
    localparam int SAMPLE_BITS_DEFAULT = 16;

    // reset values of the registers
    localparam logic [CNT_W-1:0] SAMPLE_COUNT_RESET = CNT_W'(8);

    typedef logic [PAT_W-1:0]   pat_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [LABEL_W-1:0] label_t;
    typedef logic [POP_W-1:0]   pop_t;
    typedef logic [TAB_DEPTH-1:0][LABEL_W-1:0] lbl_tab_t;

    typedef enum logic [MODE_W-1:0] {
        MAP_IDENTITY = 2'd0,
        MAP_UNIFORM  = 2'd1,
        MAP_ROT_INV  = 2'd2,
        MAP_RIU      = 2'd3
    } map_mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAPPING_MODE = 1'b0,
        REG_SAMPLE_COUNT = 1'b1
    } cfg_reg_t;

    // control that travels with a request down the pipeline
    typedef struct packed {
        logic      valid;
        map_mode_t mode;
        cnt_t      p;
    } stage_ctl_t;

    // low p bits set, p in 1..PAT_W
    function automatic pat_t pat_mask(input cnt_t p);
        logic [PAT_W:0] full;
        full = (PAT_W+1)'(1) << p;
        return PAT_W'(full - (PAT_W+1)'(1));
    endfunction

    // circular rotate left by one within p bits
    function automatic pat_t rot_left(input pat_t v, input cnt_t p);
        pat_t m;
        pat_t vv;
        m  = pat_mask(p);
        vv = v & m;
        return ((vv << 1) | (vv >> (p - CNT_W'(1)))) & m;
    endfunction

    function automatic pop_t pop_count(input pat_t v);
        pop_t n;
        n = '0;
        for (int i = 0; i < PAT_W; i++) begin
            n = n + POP_W'(v[i]);
        end
        return n;
    endfunction

    // at most two circular transitions
    function automatic logic is_uniform(input pat_t v, input cnt_t p);
        return pop_count(v ^ rot_left(v, p)) <= POP_W'(2);
    endfunction

    // smallest circular rotation; each rotation is formed on its own
    function automatic pat_t min_rot(input pat_t v, input cnt_t p);
        pat_t m;
        pat_t vv;
        pat_t r;
        pat_t best;
        m    = pat_mask(p);
        vv   = v & m;
        best = vv;
        for (int k = 1; k < PAT_W; k++) begin
            if (CNT_W'(k) < p) begin
                r = ((vv << k) | (vv >> (p - CNT_W'(k)))) & m;
                if (r < best) begin
                    best = r;
                end
            end
        end
        return best;
    endfunction

    // rank table for one sample count: entry v counts the qualifying
    // patterns below v (uniform ones, or minimal-rotation representatives)
    function automatic lbl_tab_t build_tab(input cnt_t p, input logic uniform_kind);
        lbl_tab_t tab;
        label_t   count;
        pat_t     v;
        logic     hit;
        tab   = '0;
        count = '0;
        for (int i = 0; i < TAB_DEPTH; i++) begin
            v = PAT_W'(i);
            if (i < (1 << p)) begin
                hit    = uniform_kind ? is_uniform(v, p) : (min_rot(v, p) == v);
                tab[v] = count;
                if (hit) begin
                    count = count + LABEL_W'(1);
                end
            end
        end
        return tab;
    endfunction

endpackage

[rtl/lbp_lane.sv]
// lbp_lane: one comparator lane, sample against centre, registered pattern bit.
// Depends on lbp_pkg.
module lbp_lane #(
    parameter int SAMPLE_BITS = lbp_pkg::SAMPLE_BITS_DEFAULT,
    parameter int LANE_IDX    = 0
) (
    input  logic                   clk,
    input  logic [SAMPLE_BITS-1:0] centre,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  lbp_pkg::cnt_t          p,
    output logic                   bit_reg
);
    import lbp_pkg::*;

    logic lane_en;
    logic bit_next;

    // lane takes part only below the effective sample count
    assign lane_en  = CNT_W'(LANE_IDX) < p;
    assign bit_next = lane_en && (sample >= centre);

    always_ff @(posedge clk)
    begin
        bit_reg <= bit_next;
    end

endmodule

[rtl/lbp_map.sv]
// lbp_map: merging stage, turns the lane bits into the mapped label.
// Stage two finds uniformity, popcount and minimal rotation; stage three reads
// the per-count rank tables. Depends on lbp_pkg.
module lbp_map #(
    parameter int LANES = lbp_pkg::MAX_SAMPLES_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lbp_pkg::stage_ctl_t s1_ctl,
    input  lbp_pkg::pat_t       s1_pat,
    output logic                done,
    output lbp_pkg::pat_t       raw_pattern,
    output lbp_pkg::label_t     mapped_label
);
    import lbp_pkg::*;

    stage_ctl_t s2_ctl_reg;
    pat_t       s2_pat_reg;
    pat_t       s2_minrot_reg;
    logic       s2_uni_reg;
    pop_t       s2_pop_reg;

    logic       done_reg;
    pat_t       raw_pattern_reg;
    label_t     mapped_label_reg;
    label_t     mapped_label_next;

    label_t     uni_lbl [LANES];
    label_t     rot_lbl [LANES];
    label_t     uni_sel;
    label_t     rot_sel;
    label_t     p_ext;

    // stage two control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctl_reg <= '0;
        end
        else
        begin
            s2_ctl_reg <= s1_ctl;
        end
    end

    // stage two pattern properties
    always_ff @(posedge clk)
    begin
        s2_pat_reg    <= s1_pat;
        s2_minrot_reg <= min_rot(s1_pat, s1_ctl.p);
        s2_uni_reg    <= is_uniform(s1_pat, s1_ctl.p);
        s2_pop_reg    <= pop_count(s1_pat);
    end

    // one pair of rank tables for each sample count
    for (genvar g = 0; g < LANES; g++)
    begin : g_tab
        localparam lbl_tab_t UNI_TAB = build_tab(CNT_W'(g + 1), 1'b1);
        localparam lbl_tab_t ROT_TAB = build_tab(CNT_W'(g + 1), 1'b0);
        assign uni_lbl[g] = UNI_TAB[s2_pat_reg];
        assign rot_lbl[g] = ROT_TAB[s2_minrot_reg];
    end

    // pick the tables of the current count
    always_comb
    begin
        uni_sel = '0;
        rot_sel = '0;
        for (int g = 0; g < LANES; g++)
        begin
            if (s2_ctl_reg.p == CNT_W'(g + 1))
            begin
                uni_sel = uni_lbl[g];
                rot_sel = rot_lbl[g];
            end
        end
    end

    assign p_ext = LABEL_W'(s2_ctl_reg.p);

    // label by mapping mode
    always_comb
    begin
        unique case (s2_ctl_reg.mode)
            MAP_IDENTITY: mapped_label_next = LABEL_W'(s2_pat_reg);
            MAP_UNIFORM:  mapped_label_next = s2_uni_reg ? uni_sel
                                            : p_ext * (p_ext - LABEL_W'(1)) + LABEL_W'(2);
            MAP_ROT_INV:  mapped_label_next = rot_sel;
            MAP_RIU:      mapped_label_next = s2_uni_reg ? LABEL_W'(s2_pop_reg)
                                            : p_ext + LABEL_W'(1);
            default:      mapped_label_next = '0;
        endcase
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2_ctl_reg.valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        raw_pattern_reg  <= s2_pat_reg;
        mapped_label_reg <= mapped_label_next;
    end

    assign done         = done_reg;
    assign raw_pattern  = raw_pattern_reg;
    assign mapped_label = mapped_label_reg;

endmodule

[rtl/lbp_code_with_mapping.sv]
// lbp_code_with_mapping: local binary pattern with label mapping, top level.
// Pipeline: an accepted request goes through the lane compare, pattern properties
// and rank table read registers before its result strobe (done) rises.
// Throughput: one request per cycle; busy stays low and done cannot be stalled.
// Reset: rst_n clears the pipeline valids, mapping_mode to 0 and sample_count to 8.
module lbp_code_with_mapping #(
    parameter int MAX_SAMPLES = lbp_pkg::MAX_SAMPLES_DEFAULT,
    parameter int SAMPLE_BITS = lbp_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [lbp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lbp_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic [SAMPLE_BITS-1:0]              centre_value,
    input  logic [SAMPLE_BITS-1:0]              sample_0,
    input  logic [SAMPLE_BITS-1:0]              sample_1,
    input  logic [SAMPLE_BITS-1:0]              sample_2,
    input  logic [SAMPLE_BITS-1:0]              sample_3,
    input  logic [SAMPLE_BITS-1:0]              sample_4,
    input  logic [SAMPLE_BITS-1:0]              sample_5,
    input  logic [SAMPLE_BITS-1:0]              sample_6,
    input  logic [SAMPLE_BITS-1:0]              sample_7,
    output logic                                done,
    output logic [lbp_pkg::PAT_W-1:0]           raw_pattern,
    output logic [lbp_pkg::LABEL_W-1:0]         mapped_label
);
    import lbp_pkg::*;

    localparam int LANES = (MAX_SAMPLES < SAMPLE_FIELDS) ? MAX_SAMPLES : SAMPLE_FIELDS;

    map_mode_t  mapping_mode_reg;
    cnt_t       sample_count_reg;
    cnt_t       p_eff;
    logic       accept;
    stage_ctl_t s1_ctl_reg;
    pat_t       s1_pat;

    logic [SAMPLE_BITS-1:0] samples [SAMPLE_FIELDS];

    assign samples[0] = sample_0;
    assign samples[1] = sample_1;
    assign samples[2] = sample_2;
    assign samples[3] = sample_3;
    assign samples[4] = sample_4;
    assign samples[5] = sample_5;
    assign samples[6] = sample_6;
    assign samples[7] = sample_7;

    // pipeline always takes a request
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mapping_mode_reg <= MAP_IDENTITY;
            sample_count_reg <= SAMPLE_COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MAPPING_MODE: mapping_mode_reg <= map_mode_t'(cfg_data[MODE_W-1:0]);
                REG_SAMPLE_COUNT: sample_count_reg <= cfg_data[CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // effective sample count, clamped to 1..LANES
    always_comb
    begin
        if (sample_count_reg == '0)
        begin
            p_eff = CNT_W'(1);
        end
        else if (sample_count_reg > CNT_W'(LANES))
        begin
            p_eff = CNT_W'(LANES);
        end
        else
        begin
            p_eff = sample_count_reg;
        end
    end

    // stage one control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
        end
        else
        begin
            s1_ctl_reg.valid <= accept;
            s1_ctl_reg.mode  <= mapping_mode_reg;
            s1_ctl_reg.p     <= p_eff;
        end
    end

    // comparator lanes
    for (genvar g = 0; g < SAMPLE_FIELDS; g++)
    begin : g_lane
        if (g < LANES)
        begin : g_on
            lbp_lane #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .LANE_IDX    (g)
            ) u_lane (
                .clk     (clk),
                .centre  (centre_value),
                .sample  (samples[g]),
                .p       (p_eff),
                .bit_reg (s1_pat[g])
            );
        end
        else
        begin : g_off
            assign s1_pat[g] = 1'b0;
        end
    end

    // merge lanes into the label
    lbp_map #(
        .LANES (LANES)
    ) u_map (
        .clk          (clk),
        .rst_n        (rst_n),
        .s1_ctl       (s1_ctl_reg),
        .s1_pat       (s1_pat),
        .done         (done),
        .raw_pattern  (raw_pattern),
        .mapped_label (mapped_label)
    );

endmodule

[tb/lbp_checker.sv]
// lbp_checker: watches the request, config and result ports of the lbp block,
// predicts pattern and label for each accepted request and compares them.
// Depends on lbp_pkg for widths, mode codes and register codes.
module lbp_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [lbp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lbp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            start,
    input  logic                            busy,
    input  logic [15:0]                     centre_value,
    input  logic [15:0]                     sample_0,
    input  logic [15:0]                     sample_1,
    input  logic [15:0]                     sample_2,
    input  logic [15:0]                     sample_3,
    input  logic [15:0]                     sample_4,
    input  logic [15:0]                     sample_5,
    input  logic [15:0]                     sample_6,
    input  logic [15:0]                     sample_7,
    input  logic                            done,
    input  lbp_pkg::pat_t                   raw_pattern,
    input  lbp_pkg::label_t                 mapped_label,
    output int                              errors,
    output int                              waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    import lbp_pkg::*;

    typedef logic [15:0] word_t;

    typedef struct packed {
        pat_t   pat;
        label_t label;
    } lbp_result_t;

    lbp_result_t expected_q[$];
    map_mode_t   cur_mode;
    cnt_t        cur_count;

    // low p bits set
    function automatic int ring_mask(input int p);
        return (1 << p) - 1;
    endfunction

    // circular shift left by one inside a p-bit ring
    function automatic int ring_step(input int v, input int p);
        int m;
        m = ring_mask(p);
        v = v & m;
        return ((v << 1) | (v >> (p - 1))) & m;
    endfunction

    function automatic int ones(input int v);
        int n;
        n = 0;
        for (int i = 0; i < 16; i++) begin
            n += (v >> i) & 1;
        end
        return n;
    endfunction

    // uniform: at most two 0/1 changes around the ring
    function automatic bit few_edges(input int v, input int p);
        return ones(v ^ ring_step(v, p)) <= 2;
    endfunction

    function automatic int ring_min(input int v, input int p);
        int best;
        int r;
        best = v & ring_mask(p);
        r    = best;
        for (int k = 1; k < p; k++) begin
            r = ring_step(r, p);
            if (r < best) begin
                best = r;
            end
        end
        return best;
    endfunction

    // pattern and label for one neighbourhood under the given settings
    function automatic lbp_result_t lbp_predict(input map_mode_t mode, input cnt_t count,
                                                input word_t c, input word_t s [8]);
        int          p;
        int          code;
        int          lbl;
        int          rm;
        lbp_result_t r;
        p = int'(count);
        if (p < 1) begin
            p = 1;
        end
        if (p > 8) begin
            p = 8;
        end
        code = 0;
        for (int i = 0; i < p; i++) begin
            if (s[i] >= c) begin
                code |= 1 << i;
            end
        end
        lbl = 0;
        case (mode)
            MAP_IDENTITY: lbl = code;
            MAP_UNIFORM: begin
                if (few_edges(code, p)) begin
                    for (int v = 0; v < code; v++) begin
                        if (few_edges(v, p)) begin
                            lbl++;
                        end
                    end
                end else begin
                    lbl = p * (p - 1) + 2;
                end
            end
            MAP_ROT_INV: begin
                rm = ring_min(code, p);
                for (int v = 0; v < rm; v++) begin
                    if (ring_min(v, p) == v) begin
                        lbl++;
                    end
                end
            end
            default: lbl = few_edges(code, p) ? ones(code) : p + 1;
        endcase
        r.pat   = pat_t'(code);
        r.label = label_t'(lbl);
        return r;
    endfunction

    function automatic void note_fail(input string msg);
        if (errors < 10) begin
            $display("%0t ns: %s", $time, msg);
        end
        errors++;
    endfunction

    // track config, queue predictions, compare results
    always @(posedge clk or negedge rst_n) begin : watch
        lbp_result_t want;
        word_t       smp [8];
        if (!rst_n) begin
            expected_q.delete();
            cur_mode  <= MAP_IDENTITY;
            cur_count <= SAMPLE_COUNT_RESET;
            errors    = 0;
            waiting   <= 0;
        end else begin
            // results leave first: a done at this edge belongs to an older request
            if (done) begin
                if (expected_q.size() == 0) begin
                    note_fail($sformatf("result with no request pending: pattern %02h label %0d",
                                        raw_pattern, mapped_label));
                end else begin
                    want = expected_q.pop_front();
                    if (raw_pattern !== want.pat) begin
                        note_fail($sformatf("raw_pattern mismatch: expected %02h, got %02h",
                                            want.pat, raw_pattern));
                    end
                    if (mapped_label !== want.label) begin
                        note_fail($sformatf("mapped_label mismatch: expected %0d, got %0d",
                                            want.label, mapped_label));
                    end
                end
            end
            // accepted request
            if (start && !busy) begin
                smp[0] = sample_0;
                smp[1] = sample_1;
                smp[2] = sample_2;
                smp[3] = sample_3;
                smp[4] = sample_4;
                smp[5] = sample_5;
                smp[6] = sample_6;
                smp[7] = sample_7;
                expected_q.push_back(lbp_predict(cur_mode, cur_count, centre_value, smp));
            end
            // register writes
            if (cfg_wr_en) begin
                if (cfg_index == REG_MAPPING_MODE) begin
                    cur_mode <= map_mode_t'(cfg_data[MODE_W-1:0]);
                end else if (cfg_index == REG_SAMPLE_COUNT) begin
                    cur_count <= cfg_data[CNT_W-1:0];
                end
            end
            waiting <= expected_q.size();
        end
    end

endmodule

[tb/tb_lbp_code_with_mapping.sv]
// tb_lbp_code_with_mapping: drives requests and register writes into the lbp
// block and gives the verdict. Depends on lbp_pkg, lbp_checker and the rtl top.
module tb_lbp_code_with_mapping;
    timeunit 1ns;
    timeprecision 1ps;

    import lbp_pkg::*;

    typedef logic [15:0] word_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   start;
    logic                   busy;
    word_t                  centre_value;
    word_t                  sample_0;
    word_t                  sample_1;
    word_t                  sample_2;
    word_t                  sample_3;
    word_t                  sample_4;
    word_t                  sample_5;
    word_t                  sample_6;
    word_t                  sample_7;
    logic                   done;
    pat_t                   raw_pattern;
    label_t                 mapped_label;
    int                     errors;
    int                     waiting;
    int                     cur_p;

    lbp_code_with_mapping u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .centre_value (centre_value),
        .sample_0     (sample_0),
        .sample_1     (sample_1),
        .sample_2     (sample_2),
        .sample_3     (sample_3),
        .sample_4     (sample_4),
        .sample_5     (sample_5),
        .sample_6     (sample_6),
        .sample_7     (sample_7),
        .done         (done),
        .raw_pattern  (raw_pattern),
        .mapped_label (mapped_label)
    );

    lbp_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .centre_value (centre_value),
        .sample_0     (sample_0),
        .sample_1     (sample_1),
        .sample_2     (sample_2),
        .sample_3     (sample_3),
        .sample_4     (sample_4),
        .sample_5     (sample_5),
        .sample_6     (sample_6),
        .sample_7     (sample_7),
        .done         (done),
        .raw_pattern  (raw_pattern),
        .mapped_label (mapped_label),
        .errors       (errors),
        .waiting      (waiting)
    );

    always #5 clk = ~clk;

    // one request; called at a rising edge, returns at the edge that takes it
    task automatic issue(input word_t c, input word_t s [8]);
        bit taken;
        start        <= 1'b1;
        centre_value <= c;
        sample_0     <= s[0];
        sample_1     <= s[1];
        sample_2     <= s[2];
        sample_3     <= s[3];
        sample_4     <= s[4];
        sample_5     <= s[5];
        sample_6     <= s[6];
        sample_7     <= s[7];
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
    endtask

    // samples chosen so that the wanted bits compare at or above the centre
    task automatic send_pattern(input logic [7:0] want, input word_t c);
        word_t s [8];
        for (int i = 0; i < 8; i++) begin
            if (want[i]) begin
                s[i] = word_t'($urandom_range(65535, c));
            end else if (c == 0) begin
                s[i] = '0;
            end else begin
                s[i] = word_t'($urandom_range(c - 1, 0));
            end
        end
        issue(c, s);
    endtask

    // mostly shaped patterns, uniform runs often, some fully random fields
    task automatic send_random(input int p);
        int          style;
        int          run;
        int          k;
        int          w;
        word_t       c;
        word_t       s [8];
        logic [7:0]  want;
        logic [7:0]  ring;
        style = $urandom_range(7);
        if (style == 0) begin
            c = word_t'($urandom);
            for (int i = 0; i < 8; i++) begin
                s[i] = word_t'($urandom);
            end
            issue(c, s);
        end else begin
            case ($urandom_range(9))
                0:       c = '0;
                1:       c = '1;
                default: c = word_t'($urandom);
            endcase
            if (style < 5) begin
                run  = $urandom_range(p);
                k    = $urandom_range(p - 1);
                w    = (1 << run) - 1;
                w    = ((w << k) | (w >> (p - k))) & ((1 << p) - 1);
                ring = 8'((1 << p) - 1);
                want = 8'(w) | (8'($urandom) & ~ring);
            end else begin
                want = 8'($urandom);
            end
            send_pattern(want, c);
        end
    endtask

    // sender idle cycles before the next request
    task automatic idle_gap(input int pct);
        while ($urandom_range(99) < pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // stop sending, let every pending result come back, then let the pipeline run empty
    task automatic settle();
        start <= 1'b0;
        do begin
            @(negedge clk);
        end while (waiting != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input map_mode_t mode, input cnt_t count);
        settle();
        write_reg(REG_MAPPING_MODE, CFG_DATA_W'(mode));
        write_reg(REG_SAMPLE_COUNT, CFG_DATA_W'(count));
        cur_p = (count < 1) ? 1 : (count > 8) ? 8 : int'(count);
    endtask

    // stimulus
    initial begin : stim
        word_t lo_s [8];
        word_t hi_s [8];
        int    counts [12];
        int    idle_pct [3];
        cfg_wr_en    <= 1'b0;
        cfg_index    <= REG_MAPPING_MODE;
        cfg_data     <= '0;
        start        <= 1'b0;
        centre_value <= '0;
        sample_0     <= '0;
        sample_1     <= '0;
        sample_2     <= '0;
        sample_3     <= '0;
        sample_4     <= '0;
        sample_5     <= '0;
        sample_6     <= '0;
        sample_7     <= '0;
        lo_s     = '{default: 16'h0000};
        hi_s     = '{default: 16'hFFFF};
        counts   = '{8, 1, 15, 0, 2, 3, 4, 5, 6, 7, 9, 8};
        idle_pct = '{0, 75, 24};
        cur_p    = 8;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes, equal values and one uniform and one non-uniform
        // pattern under every mode
        for (int m = 0; m < 4; m++) begin
            configure(map_mode_t'(m), cnt_t'(8));
            issue(16'h0000, lo_s);
            issue(16'hFFFF, hi_s);
            issue(16'hFFFF, lo_s);
            send_pattern(8'h55, 16'h8000);
            send_pattern(8'hF7, 16'h1234);
        end
        // sample count zero acts as one
        configure(MAP_UNIFORM, cnt_t'(0));
        send_pattern(8'h01, 16'h4000);
        send_pattern(8'hFE, 16'h4000);
        // sample count above eight saturates
        configure(MAP_ROT_INV, cnt_t'(15));
        send_pattern(8'h96, 16'h0F00);
        configure(MAP_RIU, cnt_t'(1));
        send_pattern(8'h01, 16'hFFFF);

        // random phases over mode, sample count and sender idling
        for (int ph = 0; ph < 12; ph++) begin
            configure(map_mode_t'(ph % 4), cnt_t'(counts[ph]));
            repeat (75) begin
                idle_gap(idle_pct[ph % 3]);
                send_random(cur_p);
            end
        end

        settle();
        repeat (10) @(posedge clk);
        if (errors == 0 && waiting == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // hang guard
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
